>>> rtl/rbm_hat_pkg.sv
// Shared definitions for the RBM hidden activation table.
// Opcodes, status codes, parameter defaults and the ALU control group.
// No dependencies.
`timescale 1ns / 1ps

package rbm_hat_pkg;

  // Parameter defaults
  localparam int MAX_SITES_DEF   = 16;
  localparam int MAX_DENSITY_DEF = 2;
  localparam int WEIGHT_BITS_DEF = 16;
  localparam int ACT_BITS_DEF    = 24;

  // Command opcodes
  localparam logic [2:0] OP_LOAD_W  = 3'd0;
  localparam logic [2:0] OP_LOAD_B  = 3'd1;
  localparam logic [2:0] OP_REBUILD = 3'd2;
  localparam logic [2:0] OP_HOP     = 3'd3;
  localparam logic [2:0] OP_READ    = 3'd4;

  // Result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_SAT   = 2'd2;

  // Configuration register indexes (paddr[2])
  localparam logic REG_SITES   = 1'b0;
  localparam logic REG_DENSITY = 1'b1;

  // Operand selection for the shared add/saturate unit
  typedef struct packed {
    logic hop;    // base is the table entry, add to-row, subtract from-row
    logic first;  // rebuild: base is the hidden bias
    logic occ;    // rebuild: visible unit occupied, add the weight
  } alu_ctrl_t;

endpackage

>>> rtl/rbm_hidden_activation_table.sv
// Top level of the RBM hidden activation table: APB registers, sequencer,
// weight/bias/activation memories. Depends on rbm_hat_pkg and rbm_hat_alu.
`timescale 1ns / 1ps

// Channel   | Handshake                         | Beat
// ----------+-----------------------------------+-------------------------------
// command   | start & !busy                     | opcode_i .. from_site_i
// result    | done_o (one-cycle strobe)         | activation_o, status_o
// config    | psel & penable & pwrite (pready=1)| paddr[2] selects, pwdata
//
// Loads and out-of-range or unknown commands answer from the run state, a read
// from the flush state; a hop walks the H hidden units, a rebuild the H*V weights
// (V = 2*sites, H = V*density), before flushing. One weight entry per cycle goes
// through the shared adder on a rebuild; a hop reads from two weight rows and
// the table entry per cycle. busy drops with the strobe. The table clears at
// reset through per-entry valid bits; the receiver cannot stall.

module rbm_hidden_activation_table #(
  parameter int MAX_SITES   = rbm_hat_pkg::MAX_SITES_DEF,
  parameter int MAX_DENSITY = rbm_hat_pkg::MAX_DENSITY_DEF,
  parameter int WEIGHT_BITS = rbm_hat_pkg::WEIGHT_BITS_DEF,
  parameter int ACT_BITS    = rbm_hat_pkg::ACT_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // command
  input  logic                       start,
  output logic                       busy,
  input  logic [2:0]                 opcode_i,
  input  logic [4:0]                 visible_index_i,
  input  logic [5:0]                 hidden_index_i,
  input  logic signed [15:0]         param_value_i,
  input  logic [31:0]                occupancy_i,
  input  logic                       spin_i,
  input  logic [3:0]                 to_site_i,
  input  logic [3:0]                 from_site_i,
  // result
  output logic                       done_o,
  output logic signed [ACT_BITS-1:0] activation_o,
  output logic [1:0]                 status_o
);
  import rbm_hat_pkg::*;

  localparam int NV_MAX  = 2 * MAX_SITES;
  localparam int NH_MAX  = NV_MAX * MAX_DENSITY;
  localparam int ROW_W   = $clog2(NV_MAX);
  localparam int HID_W   = $clog2(NH_MAX);
  localparam int WADDR_W = $clog2(NV_MAX * NH_MAX);
  localparam int SITE_W  = $clog2(MAX_SITES + 1);
  localparam int DEN_W   = $clog2(MAX_DENSITY + 1);
  localparam int NV_W    = $clog2(NV_MAX + 1);
  localparam int NH_W    = $clog2(NH_MAX + 1);
  localparam int SUM_W   = WEIGHT_BITS + $clog2(NV_MAX + 1);
  localparam int ACC_W   = ((SUM_W > ACT_BITS + 1) ? SUM_W : ACT_BITS + 1) + 1;
  localparam int PV_W    = (WEIGHT_BITS > 16) ? WEIGHT_BITS : 16;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RUN   = 3'b010,
    S_FLUSH = 3'b100
  } state_e;

  state_e state_q, state_d;

  // config registers
  logic [4:0]        active_sites_q;
  logic [1:0]        hidden_density_q;
  logic              cfg_we;

  // latched command
  logic [2:0]              op_q;
  logic [4:0]              vi_q;
  logic [5:0]              hi_q;
  logic signed [15:0]      pv_q;
  logic [NV_MAX-1:0]       occ_q;
  logic                    spin_q;
  logic [3:0]              ts_q;
  logic [3:0]              fs_q;

  // sequencer counters
  logic [HID_W-1:0]  h_q, h_d;
  logic [ROW_W-1:0]  v_q, v_d;
  logic              accept;
  logic              issue;

  // effective sizes
  logic [SITE_W-1:0] s_eff;
  logic [DEN_W-1:0]  d_eff;
  logic [NV_W-1:0]   nv;
  logic [NH_W-1:0]   nh;

  logic              load_w_bad, hid_bad, hop_bad, last_v, last_h;
  logic [ROW_W-1:0]  to_row, from_row, wrow0, wrow1;

  // load value clamp
  logic signed [PV_W-1:0]        pv_ext;
  logic [PV_W-WEIGHT_BITS:0]     pv_top;
  logic                          pv_sat;
  logic signed [WEIGHT_BITS-1:0] pv_w;

  // memories
  logic signed [WEIGHT_BITS-1:0] w_mem [NV_MAX*NH_MAX];
  logic signed [WEIGHT_BITS-1:0] bias_mem [NH_MAX];
  logic signed [ACT_BITS-1:0]    act_mem [NH_MAX];
  logic [NH_MAX-1:0]             act_vld_q;
  logic                          w_we, b_we, act_we;
  logic [WADDR_W-1:0]            w_waddr, w_raddr0, w_raddr1;
  logic [HID_W-1:0]              act_raddr;
  logic signed [WEIGHT_BITS-1:0] w0_rd_q, w1_rd_q, bias_rd_q;
  logic signed [ACT_BITS-1:0]    act_rd_q;
  logic                          act_vld_rd_q;

  // second stage: data back from memory
  logic              b_valid_q, b_first_q, b_last_q, b_occ_q;
  logic [HID_W-1:0]  b_h_q;
  logic signed [ACC_W-1:0]    acc_q;
  alu_ctrl_t                  alu_ctrl;
  logic signed [ACC_W-1:0]    alu_sum;
  logic signed [ACT_BITS-1:0] alu_val;
  logic signed [ACT_BITS-1:0] act_base;
  logic                       alu_sat;
  logic                       sat_now, sat_q;

  // result
  logic                       resp;
  logic signed [ACT_BITS-1:0] resp_act;
  logic [1:0]                 resp_stat;
  logic                       done_q;
  logic signed [ACT_BITS-1:0] act_out_q;
  logic [1:0]                 status_q;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_DENSITY) ? {30'd0, hidden_density_q}
                                            : {27'd0, active_sites_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_sites_q   <= 5'd16;
      hidden_density_q <= 2'd1;
    end else if (cfg_we) begin
      if (paddr[2] == REG_SITES) begin
        active_sites_q <= pwdata[4:0];
      end else begin
        hidden_density_q <= pwdata[1:0];
      end
    end
  end

  // clamp registers into their legal ranges
  always_comb begin
    if (active_sites_q == '0) begin
      s_eff = SITE_W'(1);
    end else if (32'(active_sites_q) > MAX_SITES) begin
      s_eff = SITE_W'(MAX_SITES);
    end else begin
      s_eff = SITE_W'(active_sites_q);
    end
    if (hidden_density_q == '0) begin
      d_eff = DEN_W'(1);
    end else if (32'(hidden_density_q) > MAX_DENSITY) begin
      d_eff = DEN_W'(MAX_DENSITY);
    end else begin
      d_eff = DEN_W'(hidden_density_q);
    end
  end

  assign nv = NV_W'(32'(s_eff) * 32'd2);
  assign nh = NH_W'(32'(nv) * 32'(d_eff));

  // ---------------- range checks and rows ----------------
  assign load_w_bad = (32'(vi_q) >= 32'(nv)) || (32'(hi_q) >= 32'(nh));
  assign hid_bad    = 32'(hi_q) >= 32'(nh);
  assign hop_bad    = (32'(ts_q) >= 32'(s_eff)) || (32'(fs_q) >= 32'(s_eff));
  assign to_row     = spin_q ? ROW_W'(ts_q) : ROW_W'(32'(ts_q) + 32'(s_eff));
  assign from_row   = spin_q ? ROW_W'(fs_q) : ROW_W'(32'(fs_q) + 32'(s_eff));
  assign last_v     = (32'(v_q) + 32'd1) == 32'(nv);
  assign last_h     = (32'(h_q) + 32'd1) == 32'(nh);

  // saturate the loaded value to the weight width
  assign pv_ext = PV_W'(pv_q);
  assign pv_top = pv_ext[PV_W-1:WEIGHT_BITS-1];
  assign pv_sat = !((&pv_top) || !(|pv_top));
  assign pv_w   = pv_sat ? {pv_ext[PV_W-1], {(WEIGHT_BITS-1){~pv_ext[PV_W-1]}}}
                         : pv_ext[WEIGHT_BITS-1:0];

  // ---------------- sequencer ----------------
  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  always_comb begin
    state_d   = state_q;
    h_d       = h_q;
    v_d       = v_q;
    issue     = 1'b0;
    w_we      = 1'b0;
    b_we      = 1'b0;
    resp      = 1'b0;
    resp_act  = '0;
    resp_stat = STAT_OK;
    wrow0     = v_q;
    wrow1     = from_row;
    act_raddr = h_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_RUN;
          h_d     = '0;
          v_d     = '0;
        end
      end
      S_RUN: begin
        case (op_q)
          OP_LOAD_W: begin
            resp    = 1'b1;
            state_d = S_IDLE;
            if (load_w_bad) begin
              resp_stat = STAT_RANGE;
            end else begin
              w_we      = 1'b1;
              resp_stat = pv_sat ? STAT_SAT : STAT_OK;
            end
          end
          OP_LOAD_B: begin
            resp    = 1'b1;
            state_d = S_IDLE;
            if (hid_bad) begin
              resp_stat = STAT_RANGE;
            end else begin
              b_we      = 1'b1;
              resp_stat = pv_sat ? STAT_SAT : STAT_OK;
            end
          end
          OP_REBUILD: begin
            // inner walk over visible rows, outer over hidden units
            issue = 1'b1;
            wrow0 = v_q;
            if (last_v) begin
              v_d = '0;
              if (last_h) begin
                state_d = S_FLUSH;
              end else begin
                h_d = h_q + HID_W'(1);
              end
            end else begin
              v_d = v_q + ROW_W'(1);
            end
          end
          OP_HOP: begin
            if (hop_bad) begin
              resp      = 1'b1;
              resp_stat = STAT_RANGE;
              state_d   = S_IDLE;
            end else begin
              issue = 1'b1;
              wrow0 = to_row;
              wrow1 = from_row;
              if (last_h) begin
                state_d = S_FLUSH;
              end else begin
                h_d = h_q + HID_W'(1);
              end
            end
          end
          OP_READ: begin
            if (hid_bad) begin
              resp      = 1'b1;
              resp_stat = STAT_RANGE;
              state_d   = S_IDLE;
            end else begin
              act_raddr = HID_W'(hi_q);
              state_d   = S_FLUSH;
            end
          end
          default: begin
            resp    = 1'b1;
            state_d = S_IDLE;
          end
        endcase
      end
      S_FLUSH: begin
        // last beat leaves the second stage in this cycle
        resp    = 1'b1;
        state_d = S_IDLE;
        if (op_q == OP_READ) begin
          resp_act = act_vld_rd_q ? act_rd_q : '0;
        end else begin
          resp_stat = (sat_q || sat_now) ? STAT_SAT : STAT_OK;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      h_q       <= '0;
      v_q       <= '0;
      b_valid_q <= 1'b0;
      b_first_q <= 1'b0;
      b_last_q  <= 1'b0;
      b_occ_q   <= 1'b0;
      sat_q     <= 1'b0;
      done_q    <= 1'b0;
      act_vld_q <= '0;
    end else begin
      state_q   <= state_d;
      h_q       <= h_d;
      v_q       <= v_d;
      b_valid_q <= issue;
      b_first_q <= (v_q == '0);
      b_last_q  <= last_v;
      b_occ_q   <= occ_q[v_q];
      done_q    <= resp;
      if (accept) begin
        sat_q <= 1'b0;
      end else if (sat_now) begin
        sat_q <= 1'b1;
      end
      if (act_we) begin
        act_vld_q[b_h_q] <= 1'b1;
      end
    end
  end

  // command and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= opcode_i;
      vi_q   <= visible_index_i;
      hi_q   <= hidden_index_i;
      pv_q   <= param_value_i;
      occ_q  <= NV_MAX'(occupancy_i);
      spin_q <= spin_i;
      ts_q   <= to_site_i;
      fs_q   <= from_site_i;
    end
    b_h_q <= h_q;
    if (b_valid_q && (op_q == OP_REBUILD)) begin
      acc_q <= alu_sum;
    end
    if (resp) begin
      act_out_q <= resp_act;
      status_q  <= resp_stat;
    end
  end

  // ---------------- memories ----------------
  assign w_waddr  = WADDR_W'(32'(ROW_W'(vi_q)) * NH_MAX + 32'(HID_W'(hi_q)));
  assign w_raddr0 = WADDR_W'(32'(wrow0) * NH_MAX + 32'(h_q));
  assign w_raddr1 = WADDR_W'(32'(wrow1) * NH_MAX + 32'(h_q));

  always_ff @(posedge clk_i) begin
    if (w_we) begin
      w_mem[w_waddr] <= pv_w;
    end
    w0_rd_q <= w_mem[w_raddr0];
    w1_rd_q <= w_mem[w_raddr1];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      bias_mem[HID_W'(hi_q)] <= pv_w;
    end
    bias_rd_q <= bias_mem[h_q];
  end

  always_ff @(posedge clk_i) begin
    if (act_we) begin
      act_mem[b_h_q] <= alu_val;
    end
    act_rd_q     <= act_mem[act_raddr];
    act_vld_rd_q <= act_vld_q[act_raddr];
  end

  // ---------------- shared accumulate unit ----------------
  assign alu_ctrl.hop   = (op_q == OP_HOP);
  assign alu_ctrl.first = b_first_q;
  assign alu_ctrl.occ   = b_occ_q;
  assign act_base       = act_vld_rd_q ? act_rd_q : '0;

  rbm_hat_alu #(
    .WEIGHT_BITS (WEIGHT_BITS),
    .ACT_BITS    (ACT_BITS),
    .ACC_W       (ACC_W)
  ) u_alu (
    .ctrl_i    (alu_ctrl),
    .acc_i     (acc_q),
    .bias_i    (bias_rd_q),
    .act_i     (act_base),
    .w0_i      (w0_rd_q),
    .w1_i      (w1_rd_q),
    .sum_o     (alu_sum),
    .sat_val_o (alu_val),
    .sat_o     (alu_sat)
  );

  // write back on every hop beat and on the last row of a rebuild
  assign act_we  = b_valid_q && ((op_q == OP_HOP) || b_last_q);
  assign sat_now = act_we && alu_sat;

  assign done_o       = done_q;
  assign activation_o = act_out_q;
  assign status_o     = status_q;

  // ---------------- assertions ----------------
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_accept_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_RUN))
    else $error("accepted command did not start the sequencer");

  a_we_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_we |-> ((state_q == S_RUN) || (state_q == S_FLUSH)))
    else $error("table write outside of a command");

  a_flush_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FLUSH) |=> done_o)
    else $error("flush did not deliver a result");

endmodule

>>> rtl/rbm_hat_alu.sv
// Shared accumulate unit: base + add - sub, then saturation to ACT_BITS.
// Depends on rbm_hat_pkg (alu_ctrl_t).
`timescale 1ns / 1ps

module rbm_hat_alu #(
  parameter int WEIGHT_BITS = rbm_hat_pkg::WEIGHT_BITS_DEF,
  parameter int ACT_BITS    = rbm_hat_pkg::ACT_BITS_DEF,
  parameter int ACC_W       = 32
) (
  input  rbm_hat_pkg::alu_ctrl_t        ctrl_i,
  input  logic signed [ACC_W-1:0]       acc_i,
  input  logic signed [WEIGHT_BITS-1:0] bias_i,
  input  logic signed [ACT_BITS-1:0]    act_i,
  input  logic signed [WEIGHT_BITS-1:0] w0_i,
  input  logic signed [WEIGHT_BITS-1:0] w1_i,
  output logic signed [ACC_W-1:0]       sum_o,
  output logic signed [ACT_BITS-1:0]    sat_val_o,
  output logic                          sat_o
);
  import rbm_hat_pkg::*;

  logic signed [ACC_W-1:0]      base;
  logic signed [ACC_W-1:0]      addend;
  logic signed [ACC_W-1:0]      subtr;
  logic [ACC_W-ACT_BITS:0]      top_bits;

  // operand select
  always_comb begin
    if (ctrl_i.hop) begin
      base = ACC_W'(act_i);
    end else if (ctrl_i.first) begin
      base = ACC_W'(bias_i);
    end else begin
      base = acc_i;
    end
    addend = (ctrl_i.hop || ctrl_i.occ) ? ACC_W'(w0_i) : '0;
    subtr  = ctrl_i.hop ? ACC_W'(w1_i) : '0;
  end

  assign sum_o = base + addend - subtr;

  // saturate: the bits above the activation sign must all match it
  assign top_bits  = sum_o[ACC_W-1:ACT_BITS-1];
  assign sat_o     = !((&top_bits) || !(|top_bits));
  assign sat_val_o = sat_o ? {sum_o[ACC_W-1], {(ACT_BITS-1){~sum_o[ACC_W-1]}}}
                           : sum_o[ACT_BITS-1:0];

endmodule

>>> bench/rbm_hidden_activation_table_test.sv
// Self-checking bench for rbm_hidden_activation_table: command driver, result
// checker and an in-bench model of the weight, bias and activation stores.
// Depends on rbm_hat_pkg and the block under test.
`timescale 1ns / 1ps

module rbm_hidden_activation_table_test;
  import rbm_hat_pkg::*;

  localparam int NV = 2 * MAX_SITES_DEF;
  localparam int NH = NV * MAX_DENSITY_DEF;
  localparam int ACT_W = ACT_BITS_DEF;
  localparam int ACT_HI = (1 << (ACT_W - 1)) - 1;
  localparam int ACT_LO = -(1 << (ACT_W - 1));
  localparam int SITES_MASK = 31;
  localparam int DENS_MASK = 3;
  localparam logic [2:0] OP_UNUSED_TOP = 3'd7;
  localparam int RAMP_HOPS = 132;
  localparam int DRAIN_CYCLES = 2100;

  typedef struct packed {
    logic [2:0]  op;
    logic [4:0]  vis;
    logic [5:0]  hid;
    logic [15:0] val;
    logic [31:0] occ;
    logic        spin;
    logic [3:0]  to_s;
    logic [3:0]  from_s;
  } rbm_cmd_t;

  typedef struct packed {
    logic signed [ACT_W-1:0] act;
    logic [1:0]              stat;
  } rbm_res_t;

  logic clk_i, rst_ni;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic start, busy, done_o;
  rbm_cmd_t drv;
  logic [2:0] opcode_i;
  logic [4:0] visible_index_i;
  logic [5:0] hidden_index_i;
  logic signed [15:0] param_value_i;
  logic [31:0] occupancy_i;
  logic spin_i;
  logic [3:0] to_site_i, from_site_i;
  logic signed [ACT_W-1:0] activation_o;
  logic [1:0] status_o;

  assign opcode_i        = drv.op;
  assign visible_index_i = drv.vis;
  assign hidden_index_i  = drv.hid;
  assign param_value_i   = drv.val;
  assign occupancy_i     = drv.occ;
  assign spin_i          = drv.spin;
  assign to_site_i       = drv.to_s;
  assign from_site_i     = drv.from_s;

  rbm_hidden_activation_table u_dut (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy,
    .opcode_i, .visible_index_i, .hidden_index_i, .param_value_i,
    .occupancy_i, .spin_i, .to_site_i, .from_site_i,
    .done_o, .activation_o, .status_o
  );

  // Shadow of the block's state and registers
  logic signed [15:0]      weight_copy [NV][NH];
  logic signed [15:0]      bias_copy [NH];
  logic signed [ACT_W-1:0] act_copy [NH];
  int cfg_sites, cfg_density;

  // Which store entries the stimulus has written so far
  bit w_set [NV][NH];
  bit b_set [NH];

  rbm_cmd_t cmd_backlog [$];
  rbm_res_t due_results [$];
  int up_sites [$];
  int dn_sites [$];
  bit cmd_taken;
  bit gaps_on;
  int phase_items;
  int errors, results_checked, n_rebuild, n_hop, n_sat, n_settings;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int eff_sites();
    if (cfg_sites < 1) return 1;
    if (cfg_sites > MAX_SITES_DEF) return MAX_SITES_DEF;
    return cfg_sites;
  endfunction

  function automatic int eff_nh();
    int d;
    d = cfg_density;
    if (d < 1) d = 1;
    if (d > MAX_DENSITY_DEF) d = MAX_DENSITY_DEF;
    return 2 * eff_sites() * d;
  endfunction

  function automatic logic signed [ACT_W-1:0] clip_act(input int x, output bit hit);
    hit = 1'b0;
    if (x > ACT_HI) begin
      hit = 1'b1;
      return ACT_W'(ACT_HI);
    end
    if (x < ACT_LO) begin
      hit = 1'b1;
      return ACT_W'(ACT_LO);
    end
    return x[ACT_W-1:0];
  endfunction

  // Expected outcome of one command; updates the shadow stores
  function automatic rbm_res_t step_activation_table(rbm_cmd_t c);
    int s, nv, nh, tr, fr, acc;
    bit sat, hit;
    rbm_res_t r;
    s = eff_sites();
    nv = 2 * s;
    nh = eff_nh();
    r.act = '0;
    r.stat = STAT_OK;
    sat = 1'b0;
    case (c.op)
      OP_LOAD_W: begin
        if (c.vis >= nv || c.hid >= nh) r.stat = STAT_RANGE;
        else weight_copy[c.vis][c.hid] = c.val;
      end
      OP_LOAD_B: begin
        if (c.hid >= nh) r.stat = STAT_RANGE;
        else bias_copy[c.hid] = c.val;
      end
      OP_REBUILD: begin
        for (int h = 0; h < nh; h++) begin
          acc = int'(bias_copy[h]);
          for (int v = 0; v < nv; v++)
            if (c.occ[v]) acc = acc + weight_copy[v][h];
          act_copy[h] = clip_act(acc, hit);
          sat |= hit;
        end
      end
      OP_HOP: begin
        if (c.to_s >= s || c.from_s >= s) r.stat = STAT_RANGE;
        else begin
          tr = c.spin ? int'(c.to_s) : int'(c.to_s) + s;
          fr = c.spin ? int'(c.from_s) : int'(c.from_s) + s;
          for (int h = 0; h < nh; h++) begin
            acc = act_copy[h] + weight_copy[tr][h] - weight_copy[fr][h];
            act_copy[h] = clip_act(acc, hit);
            sat |= hit;
          end
        end
      end
      OP_READ: begin
        if (c.hid >= nh) r.stat = STAT_RANGE;
        else r.act = act_copy[c.hid];
      end
      default: ;
    endcase
    if (sat) r.stat = STAT_SAT;
    return r;
  endfunction

  task automatic note_mismatch(string msg);
    errors++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Command generation
  // ---------------------------------------------------------------------------

  function automatic rbm_cmd_t rand_cmd();
    rbm_cmd_t c;
    c.op = 3'($urandom_range(0, 7));
    c.vis = 5'($urandom_range(0, 31));
    c.hid = 6'($urandom_range(0, 63));
    c.val = 16'($urandom_range(0, 65535));
    c.occ = $urandom();
    c.spin = 1'($urandom_range(0, 1));
    c.to_s = 4'($urandom_range(0, 15));
    c.from_s = 4'($urandom_range(0, 15));
    return c;
  endfunction

  function automatic rbm_cmd_t make_cmd(logic [2:0] op, int vis, int hid, int val);
    rbm_cmd_t c;
    c = rand_cmd();
    c.op = op;
    c.vis = vis[4:0];
    c.hid = hid[5:0];
    c.val = val[15:0];
    return c;
  endfunction

  function automatic rbm_cmd_t make_hop(bit up, int to_s, int from_s);
    rbm_cmd_t c;
    c = rand_cmd();
    c.op = OP_HOP;
    c.spin = up;
    c.to_s = to_s[3:0];
    c.from_s = from_s[3:0];
    return c;
  endfunction

  // Extremes often, small values sometimes, else anything
  function automatic int pick_val();
    case ($urandom_range(0, 7))
      0: return 32767;
      1: return -32768;
      2: return $urandom_range(0, 511) - 256;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic void enqueue(rbm_cmd_t c);
    if (c.op == OP_LOAD_W && c.vis < 2 * eff_sites() && c.hid < eff_nh())
      w_set[c.vis][c.hid] = 1'b1;
    if (c.op == OP_LOAD_B && c.hid < eff_nh()) b_set[c.hid] = 1'b1;
    cmd_backlog.push_back(c);
    phase_items++;
  endfunction

  function automatic bit row_ready(int v);
    for (int h = 0; h < eff_nh(); h++)
      if (!w_set[v][h]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void fill_row(int v, bit fixed, int val);
    for (int h = 0; h < eff_nh(); h++)
      enqueue(make_cmd(OP_LOAD_W, v, h, fixed ? val : pick_val()));
  endfunction

  function automatic void ensure_bias();
    for (int h = 0; h < eff_nh(); h++)
      if (!b_set[h]) enqueue(make_cmd(OP_LOAD_B, 0, h, pick_val()));
  endfunction

  function automatic void scan_sites();
    int s;
    s = eff_sites();
    up_sites.delete();
    dn_sites.delete();
    for (int k = 0; k < s; k++) begin
      if (row_ready(k)) up_sites.push_back(k);
      if (row_ready(k + s)) dn_sites.push_back(k);
    end
  endfunction

  // Prefer a row that cannot yet take part in a hop or rebuild
  function automatic void fill_some_row();
    int open_rows [$];
    int nv;
    nv = 2 * eff_sites();
    for (int v = 0; v < nv; v++)
      if (!row_ready(v)) open_rows.push_back(v);
    if (open_rows.size() > 0)
      fill_row(open_rows[$urandom_range(0, open_rows.size() - 1)], 1'b0, 0);
    else fill_row($urandom_range(0, nv - 1), 1'b0, 0);
  endfunction

  function automatic void queue_hops(int n);
    bit up;
    int a, b;
    scan_sites();
    if (up_sites.size() == 0 && dn_sites.size() == 0) begin
      fill_row($urandom_range(0, 2 * eff_sites() - 1), 1'b0, 0);
      scan_sites();
    end
    for (int k = 0; k < n; k++) begin
      if (up_sites.size() == 0) up = 1'b0;
      else if (dn_sites.size() == 0) up = 1'b1;
      else up = 1'($urandom_range(0, 1));
      if (up) begin
        a = up_sites[$urandom_range(0, up_sites.size() - 1)];
        b = up_sites[$urandom_range(0, up_sites.size() - 1)];
      end else begin
        a = dn_sites[$urandom_range(0, dn_sites.size() - 1)];
        b = dn_sites[$urandom_range(0, dn_sites.size() - 1)];
      end
      enqueue(make_hop(up, a, b));
    end
  endfunction

  // Occupancy bits only on rows whose weights are all written
  function automatic void queue_rebuild();
    rbm_cmd_t c;
    ensure_bias();
    c = make_cmd(OP_REBUILD, 0, 0, 0);
    if ($urandom_range(0, 5) == 0) c.occ = '1;
    for (int v = 0; v < 2 * eff_sites(); v++)
      if (!row_ready(v)) c.occ[v] = 1'b0;
    enqueue(c);
    n_rebuild++;
  endfunction

  function automatic void queue_reads(int n);
    int nh;
    nh = eff_nh();
    for (int k = 0; k < n; k++)
      enqueue(make_cmd(OP_READ, 0, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                              : $urandom_range(0, nh - 1), 0));
  endfunction

  // Spare opcodes, hops off the lattice, reads past the hidden layer
  function automatic void queue_noise();
    rbm_cmd_t c;
    int s, nh;
    s = eff_sites();
    nh = eff_nh();
    c = rand_cmd();
    case ($urandom_range(0, 2))
      0: c.op = 3'($urandom_range(OP_READ + 1, OP_UNUSED_TOP));
      1: begin
        if (s == MAX_SITES_DEF) c.op = 3'($urandom_range(OP_READ + 1, OP_UNUSED_TOP));
        else begin
          c.op = OP_HOP;
          if ($urandom_range(0, 1)) c.to_s = 4'($urandom_range(s, 15));
          else c.from_s = 4'($urandom_range(s, 15));
        end
      end
      default: begin
        c.op = OP_READ;
        if (nh < NH) c.hid = 6'($urandom_range(nh, NH - 1));
      end
    endcase
    enqueue(c);
  endfunction

  // Drive the table into saturation: one row at an extreme, the other at the
  // opposite extreme, then hop between them many times
  function automatic void queue_ramp(bit rising);
    int s, a, b, ra, rb;
    bit up;
    rbm_cmd_t c;
    s = eff_sites();
    a = $urandom_range(0, s - 1);
    b = (a + $urandom_range(1, s - 1)) % s;
    up = 1'($urandom_range(0, 1));
    ra = up ? a : a + s;
    rb = up ? b : b + s;
    fill_row(ra, 1'b1, rising ? 32767 : -32768);
    fill_row(rb, 1'b1, rising ? -32768 : 32767);
    ensure_bias();
    c = make_cmd(OP_REBUILD, 0, 0, 0);
    c.occ = '0;
    enqueue(c);
    n_rebuild++;
    for (int k = 0; k < RAMP_HOPS; k++) begin
      enqueue(make_hop(up, a, b));
      if (k % 16 == 15) enqueue(make_cmd(OP_READ, 0, $urandom_range(0, eff_nh() - 1), 0));
    end
  endfunction

  function automatic void queue_sequence();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 12) fill_some_row();
    else if (pick < 40) begin
      queue_hops($urandom_range(1, 6));
      if ($urandom_range(0, 1)) queue_reads(1);
    end else if (pick < 52) begin
      queue_rebuild();
      queue_reads(2);
    end else if (pick < 72) queue_reads($urandom_range(1, 4));
    else if (pick < 84) begin
      enqueue(make_cmd($urandom_range(0, 1) ? OP_LOAD_W : OP_LOAD_B,
                       $urandom_range(0, 31), $urandom_range(0, 63), pick_val()));
    end else queue_noise();
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents beats at the falling edge, records acceptance at the rising
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : take_cmds
    rbm_res_t r;
    if (rst_ni && start && busy === 1'b0) begin
      r = step_activation_table(drv);
      due_results.push_back(r);
      if (drv.op == OP_HOP) n_hop++;
      if (r.stat == STAT_SAT) n_sat++;
      cmd_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin : drive_cmds
    rbm_cmd_t nxt;
    logic go;
    nxt = drv;
    go = start;
    if (!rst_ni) go = 1'b0;
    else if (!start || cmd_taken) begin
      cmd_taken = 1'b0;
      if (cmd_backlog.size() > 0 && !(gaps_on && $urandom_range(0, 99) < 16)) begin
        nxt = cmd_backlog.pop_front();
        go = 1'b1;
      end else begin
        nxt = rand_cmd();
        go = 1'b0;
      end
    end
    drv <= nxt;
    start <= go;
  end

  // Result checker
  always @(posedge clk_i) begin : check_results
    rbm_res_t want;
    if (rst_ni && done_o !== 1'b0) begin
      if (due_results.size() == 0)
        note_mismatch($sformatf("unexpected result beat: activation %0d status %0d",
                                activation_o, status_o));
      else begin
        want = due_results.pop_front();
        results_checked++;
        if (activation_o !== want.act)
          note_mismatch($sformatf("result %0d: activation %0d, expected %0d",
                                  results_checked, activation_o, want.act));
        if (status_o !== want.stat)
          note_mismatch($sformatf("result %0d: status %0d, expected %0d",
                                  results_checked, status_o, want.stat));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Register access and phase control
  // ---------------------------------------------------------------------------

  task automatic write_reg(logic idx, int value, int mask);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= ($urandom() & ~mask) | (value & mask);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx == REG_SITES) cfg_sites = value & mask;
    else cfg_density = value & mask;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || start || due_results.size() != 0 || busy !== 1'b0)
      @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic set_lattice(int sites_raw, int dens_raw);
    write_reg(REG_SITES, sites_raw, SITES_MASK);
    write_reg(REG_DENSITY, dens_raw, DENS_MASK);
    n_settings++;
  endtask

  task automatic run_phase(int sites_raw, int dens_raw, int budget, bit steady, bit ramps);
    set_lattice(sites_raw, dens_raw);
    gaps_on = !steady;
    phase_items = 0;
    if (ramps) begin
      queue_ramp(1'b1);
      queue_ramp(1'b0);
    end
    while (phase_items < budget) queue_sequence();
    wait_drained();
  endtask

  // Stimulus
  initial begin
    rbm_cmd_t c;
    rst_ni = 1'b0;
    start = 1'b0;
    drv = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cmd_taken = 1'b0;
    gaps_on = 1'b1;
    cfg_sites = MAX_SITES_DEF;
    cfg_density = 1;
    for (int h = 0; h < NH; h++) act_copy[h] = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: both registers at zero clamp to one site, one hidden per visible
    set_lattice(0, 0);
    enqueue(make_cmd(OP_READ, 0, 0, 0));
    enqueue(make_cmd(OP_READ, 0, 63, 0));
    enqueue(make_cmd(OP_LOAD_B, 0, 0, 32767));
    enqueue(make_cmd(OP_LOAD_B, 0, 1, -32768));
    enqueue(make_cmd(OP_LOAD_W, 0, 0, 32767));
    enqueue(make_cmd(OP_LOAD_W, 0, 1, -32768));
    enqueue(make_cmd(OP_LOAD_W, 1, 0, pick_val()));
    enqueue(make_cmd(OP_LOAD_W, 1, 1, pick_val()));
    enqueue(make_cmd(OP_LOAD_W, 2, 0, 1));
    enqueue(make_cmd(OP_LOAD_W, 0, 2, -1));
    enqueue(make_cmd(OP_LOAD_W, 31, 63, 32767));
    enqueue(make_cmd(OP_LOAD_B, 0, 63, -32768));
    c = make_cmd(OP_REBUILD, 0, 0, 0);
    c.occ = '1;
    enqueue(c);
    n_rebuild++;
    enqueue(make_cmd(OP_READ, 0, 0, 0));
    enqueue(make_cmd(OP_READ, 0, 1, 0));
    enqueue(make_cmd(OP_READ, 0, 2, 0));
    enqueue(make_hop(1'b1, 0, 0));
    enqueue(make_hop(1'b0, 0, 0));
    enqueue(make_hop(1'b1, 1, 0));
    enqueue(make_hop(1'b0, 0, 15));
    for (int k = OP_READ + 1; k <= OP_UNUSED_TOP; k++) enqueue(make_cmd(k[2:0], 0, 0, 0));
    c = make_cmd(OP_REBUILD, 0, 0, 0);
    c.occ[1:0] = 2'b00;
    enqueue(c);
    n_rebuild++;
    enqueue(make_cmd(OP_READ, 0, 1, 0));
    wait_drained();

    // Random phases over several lattice sizes, extremes and clamped values
    run_phase(16, 2, 230, 1'b0, 1'b0);
    run_phase(2, 1, 320, 1'b0, 1'b1);
    run_phase(31, 3, 80, 1'b1, 1'b0);
    run_phase($urandom_range(1, 16), $urandom_range(1, 2), 70, 1'b0, 1'b0);
    run_phase(16, 1, 60, 1'b0, 1'b0);
    run_phase(1, 2, 50, 1'b0, 1'b0);
    run_phase($urandom_range(0, 31), $urandom_range(0, 3), 40, 1'b0, 1'b0);

    // Catch any stray result beat after the last one
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("Checked %0d results over %0d lattice settings: %0d rebuilds, %0d hops.",
             results_checked, n_settings, n_rebuild, n_hop);
    $display("%0d commands hit activation saturation; %0d mismatches.", n_sat, errors);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  // Run limit, several times the slowest legal run
  initial begin
    #80_000_000;
    $display("Timed out with %0d commands waiting, %0d results due.",
             cmd_backlog.size(), due_results.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
